FILE: rtl/arras_pkg.sv
// ----------------------------------------------------------------------------
// ADC round-robin average and scale: shared definitions
// Channel codes, register indexes, widths, scaling constants and the
// structures passed between the front end and the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package arras_pkg;

  localparam int ADC_W      = 10;
  localparam int VALUE_W    = 14;
  localparam int SETTLE_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;
  localparam int M_TUSER_W  = 2;

  localparam int BLOCK_LEN_DEF = 16;

  // register reset values
  localparam int SETTLE_LIMIT_RST   = 6250;
  localparam int BATTERY_OFFSET_RST = -13;
  localparam int CURRENT_ZERO_RST   = 512;
  localparam int TEMP_OFFSET_RST    = 82;

  // battery: max(avg + offset, 0) * 50 >> 8
  localparam int BAT_MUL   = 50;
  localparam int BAT_SHIFT = 8;

  // current: a * 200 / 410, done as a * ceil(200 * 2^16 / 410) >> 16,
  // exact for every ten-bit a
  localparam int CUR_NUM   = 200;
  localparam int CUR_DEN   = 410;
  localparam int CUR_SHIFT = 16;
  localparam int CUR_MUL   = (CUR_NUM * (2 ** CUR_SHIFT) + CUR_DEN - 1) / CUR_DEN;

  // temperature: ((avg * 1100 >> 10) - offset - 289) * 10
  localparam int TEMP_MUL     = 1100;
  localparam int TEMP_SHIFT   = 10;
  localparam int TEMP_BIAS_MV = 289;
  localparam int TEMP_MV_W    = 11;

  localparam int MUL_A_W = ADC_W + 1;
  localparam int MUL_K_W = 15;
  localparam int MUL_P_W = MUL_A_W + MUL_K_W;

  typedef enum logic [1:0] {
    CH_BATTERY,
    CH_CURRENT,
    CH_TEMP
  } chan_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SETTLE_LIMIT,
    CFG_BATTERY_OFFSET,
    CFG_CURRENT_ZERO,
    CFG_TEMP_OFFSET
  } cfg_reg_e;

  typedef struct packed {
    chan_e channel;
    logic  settle_started;
  } blk_info_t;

  typedef struct packed {
    logic [7:0]       battery_offset;
    logic [ADC_W-1:0] current_zero;
    logic [7:0]       temp_offset_mv;
  } scale_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/adc_round_robin_average_scale.sv
// ----------------------------------------------------------------------------
// ADC round-robin average and scale
// Averages blocks of ADC samples for battery, current and temperature in turn,
// with a settle wait after current and temperature blocks; emits scaled results.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/tready         tdata[9:0] sample
//  m_axis    out  m_axis_tvalid/tready         tdata[13:0] value, [14] settle_started
//                                              tuser[1:0] channel
//  cfg       in   cfg_we_i (no wait)           cfg_addr_i index, cfg_wdata_i data
//
//  One sample per clock while s_axis_tready is high. A block result reaches
//  m_axis through the divide, multiply and scale stages behind the register
//  that takes the block sum at the edge that accepts the block's last sample.
//  Reset loads register defaults and clears counters; no clearing pass.
//  s_axis_tready drops only while the scaler's first stage holds a block
//  sum that cannot advance because m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_round_robin_average_scale
  import arras_pkg::*;
#(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] sample
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // [13:0] value, [14] settle_started
  output logic [M_TUSER_W-1:0]       m_axis_tuser,  // [1:0] channel
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int SUM_W = $clog2(((2 ** ADC_W) - 1) * (BLOCK_LEN - 1) + 1);
  localparam int BC_W  = $clog2(BLOCK_LEN);

  logic [SETTLE_W-1:0] settle_limit_q;
  logic [7:0]          battery_offset_q;
  logic [ADC_W-1:0]    current_zero_q;
  logic [7:0]          temp_offset_q;

  logic [BC_W-1:0]     bc_q, bc_d;
  logic [SUM_W-1:0]    sum_q, sum_d, sum_add;
  chan_e               ch_q, ch_d, ch_next;
  logic [SETTLE_W-1:0] settle_q, settle_d;

  logic                accept, settle_hold, blk_last, blk_valid, blk_ready;
  logic [ADC_W-1:0]    sample;
  blk_info_t           blk_info, res_info;
  scale_cfg_t          scale_cfg;
  logic [VALUE_W-1:0]  res_value;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_limit_q   <= SETTLE_W'(SETTLE_LIMIT_RST);
      battery_offset_q <= 8'(BATTERY_OFFSET_RST);
      current_zero_q   <= ADC_W'(CURRENT_ZERO_RST);
      temp_offset_q    <= 8'(TEMP_OFFSET_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_SETTLE_LIMIT:   settle_limit_q   <= cfg_wdata_i[SETTLE_W-1:0];
        CFG_BATTERY_OFFSET: battery_offset_q <= cfg_wdata_i[7:0];
        CFG_CURRENT_ZERO:   current_zero_q   <= cfg_wdata_i[ADC_W-1:0];
        CFG_TEMP_OFFSET:    temp_offset_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign sample        = s_axis_tdata[ADC_W-1:0];
  assign s_axis_tready = blk_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign settle_hold   = (settle_q != '0) && (settle_q < settle_limit_q);
  assign blk_last      = (bc_q == BC_W'(BLOCK_LEN - 1));
  assign blk_valid     = accept && !settle_hold && blk_last;
  // first item of a block is dropped
  assign sum_add       = (bc_q != '0) ? sum_q + SUM_W'(sample) : sum_q;

  always_comb begin
    unique case (ch_q)
      CH_BATTERY: ch_next = CH_CURRENT;
      CH_CURRENT: ch_next = CH_TEMP;
      default:    ch_next = CH_BATTERY;
    endcase
  end

  assign blk_info.channel        = ch_q;
  assign blk_info.settle_started = (ch_q != CH_BATTERY);

  always_comb begin
    bc_d     = bc_q;
    sum_d    = sum_q;
    ch_d     = ch_q;
    settle_d = settle_q;
    if (accept) begin
      if (settle_hold) begin
        settle_d = settle_q + SETTLE_W'(1);
      end else if (blk_last) begin
        bc_d     = '0;
        sum_d    = '0;
        ch_d     = ch_next;
        settle_d = SETTLE_W'(blk_info.settle_started);
      end else begin
        settle_d = '0;
        bc_d     = bc_q + BC_W'(1);
        sum_d    = sum_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q     <= '0;
      sum_q    <= '0;
      ch_q     <= CH_BATTERY;
      settle_q <= '0;
    end else begin
      bc_q     <= bc_d;
      sum_q    <= sum_d;
      ch_q     <= ch_d;
      settle_q <= settle_d;
    end
  end

  assign scale_cfg.battery_offset = battery_offset_q;
  assign scale_cfg.current_zero   = current_zero_q;
  assign scale_cfg.temp_offset_mv = temp_offset_q;

  arras_scale #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg),
    .in_valid_i  (blk_valid),
    .in_ready_o  (blk_ready),
    .in_sum_i    (sum_add),
    .in_info_i   (blk_info),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (res_value),
    .out_info_o  (res_info)
  );

  assign m_axis_tdata = {{(M_TDATA_W - VALUE_W - 1){1'b0}}, res_info.settle_started,
                         res_value};
  assign m_axis_tuser = res_info.channel;

`ifndef SYNTHESIS
  a_settle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q != '0) |-> (bc_q == '0) && (sum_q == '0))
    else $error("settle wait active with a partial block");

  a_blk_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid |=> ((settle_q != '0) == ($past(ch_q) != CH_BATTERY)))
    else $error("settle wait start does not follow the channel");

  a_blk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid |=> (ch_q != $past(ch_q)) && (bc_q == '0) && (sum_q == '0))
    else $error("block end did not step the channel");
`endif

endmodule

`default_nettype wire

FILE: rtl/arras_scale.sv
// ----------------------------------------------------------------------------
// ADC round-robin average and scale: block scaler
// Pipeline from a finished block sum to one scaled result: reciprocal
// divide, channel multiply, shift and offset, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arras_scale
  import arras_pkg::*;
#(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF,
  localparam int SUM_W = $clog2(((2 ** ADC_W) - 1) * (BLOCK_LEN - 1) + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scale_cfg_t       cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [SUM_W-1:0] in_sum_i,
  input  wire blk_info_t        in_info_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [VALUE_W-1:0]    out_value_o,
  output blk_info_t             out_info_o
);

  // sum / DIV as sum * ceil(2^S / DIV) >> S, exact while sum < 2^SUM_W
  localparam int DIV         = BLOCK_LEN - 1;
  localparam int RECIP_SHIFT = SUM_W + $clog2(DIV);
  localparam int RECIP_M     = ((2 ** RECIP_SHIFT) + DIV - 1) / DIV;
  localparam int RECIP_W     = $clog2(RECIP_M + 1);
  localparam int PROD_W      = SUM_W + RECIP_W;

  logic                 s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic                 s1_ready, s2_ready, s3_ready, out_ready;
  logic [SUM_W-1:0]     s1_sum_q;
  blk_info_t            s1_info_q, s2_info_q, s3_info_q, out_info_q;
  logic [PROD_W-1:0]    div_prod;
  logic [ADC_W-1:0]     s2_avg_q;
  logic signed [11:0]   bat_sum;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_K_W-1:0]   mul_k;
  logic [MUL_P_W-1:0]   s3_prod_q;
  logic [TEMP_MV_W-1:0] temp_mv;
  logic signed [15:0]   temp_tenths;
  logic signed [15:0]   temp_scaled;
  logic [VALUE_W-1:0]   value_d, out_value_q;

  assign out_ready  = !out_v_q || out_ready_i;
  assign s3_ready   = !s3_v_q || out_ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
      if (out_ready) out_v_q <= s3_v_q;
    end
  end

  // stage 2: block average
  assign div_prod = PROD_W'(s1_sum_q) * PROD_W'(RECIP_M);

  // stage 3: channel operand and constant, one shared multiplier
  assign bat_sum = $signed({2'b00, s2_avg_q})
                 + $signed({{4{cfg_i.battery_offset[7]}}, cfg_i.battery_offset});

  always_comb begin
    unique case (s2_info_q.channel)
      CH_BATTERY: begin
        mul_a = bat_sum[11] ? '0 : bat_sum[MUL_A_W-1:0];
        mul_k = MUL_K_W'(BAT_MUL);
      end
      CH_CURRENT: begin
        mul_a = (s2_avg_q > cfg_i.current_zero) ?
                MUL_A_W'(s2_avg_q - cfg_i.current_zero) : '0;
        mul_k = MUL_K_W'(CUR_MUL);
      end
      default: begin
        mul_a = MUL_A_W'(s2_avg_q);
        mul_k = MUL_K_W'(TEMP_MUL);
      end
    endcase
  end

  // stage 4: shift, temperature offset and times ten
  assign temp_mv     = s3_prod_q[TEMP_SHIFT +: TEMP_MV_W];
  assign temp_tenths = $signed(16'(temp_mv)) - $signed(16'(cfg_i.temp_offset_mv))
                     - $signed(16'(TEMP_BIAS_MV));
  assign temp_scaled = (temp_tenths <<< 3) + (temp_tenths <<< 1);

  always_comb begin
    unique case (s3_info_q.channel)
      CH_BATTERY: value_d = VALUE_W'(s3_prod_q >> BAT_SHIFT);
      CH_CURRENT: value_d = VALUE_W'(s3_prod_q >> CUR_SHIFT);
      default:    value_d = temp_scaled[VALUE_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_sum_q  <= in_sum_i;
      s1_info_q <= in_info_i;
    end
    if (s2_ready && s1_v_q) begin
      s2_avg_q  <= div_prod[RECIP_SHIFT +: ADC_W];
      s2_info_q <= s1_info_q;
    end
    if (s3_ready && s2_v_q) begin
      s3_prod_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_k);
      s3_info_q <= s2_info_q;
    end
    if (out_ready && s3_v_q) begin
      out_value_q <= value_d;
      out_info_q  <= s3_info_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_value_o = out_value_q;
  assign out_info_o  = out_info_q;

`ifndef SYNTHESIS
  a_bat_no_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_info_q.channel == CH_BATTERY) |-> !out_info_q.settle_started)
    else $error("battery result flags a settle wait");

  a_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_info_q.channel != CH_TEMP) |-> !out_value_q[VALUE_W-1])
    else $error("battery or current result is negative");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s2_ready |=> s1_v_q && $stable(s1_sum_q))
    else $error("stalled block sum lost");
`endif

endmodule

`default_nettype wire
